FILE: rtl/ldpc_bit_flip_decoder_assert.svh
// Assertion macros for the LDPC bit-flipping decoder.
`ifndef LDPC_BIT_FLIP_DECODER_ASSERT_SVH
`define LDPC_BIT_FLIP_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define LBFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LBFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LBFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/lbfd_pkg.sv
// Shared constants, types and helpers of the LDPC bit-flipping decoder.
`timescale 1ns / 1ps
package lbfd_pkg;

  // Code geometry
  localparam int CODE_BITS  = 32;
  localparam int CHECK_ROWS = 16;

  // Field widths
  localparam int ROW_IDX_W = 4;
  localparam int WORD_W    = 32;
  localparam int ITER_W    = 8;
  localparam int CLEN_W    = 6;
  localparam int CCNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Derived widths
  localparam int ROW_AW = (CHECK_ROWS > 1) ? $clog2(CHECK_ROWS) : 1;
  localparam int N_W    = $clog2(CODE_BITS + 1);
  localparam int M_W    = $clog2(CHECK_ROWS + 1);
  localparam int CNT_W  = $clog2(CHECK_ROWS + 1);
  localparam int CB_W   = (CNT_W > 1) ? $clog2(CNT_W) : 1;

  // Register reset values
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(20);
  localparam logic [CLEN_W-1:0] CODE_LEN_RST = CLEN_W'(32);
  localparam logic [CCNT_W-1:0] CHK_CNT_RST  = CCNT_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_CODE_LEN = 2'd1,
    CFG_CHK_CNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  // Control word from the sequencer to the failure counters
  typedef struct packed {
    logic                  clear;
    logic                  accum;
    logic [CODE_BITS-1:0]  hit_row;
    logic                  srch_init;
    logic                  srch_step;
    logic [CB_W-1:0]       bit_sel;
    logic [CODE_BITS-1:0]  init_mask;
  } fail_ctl_t;

  // Bit j set when j < n
  function automatic logic [CODE_BITS-1:0] low_mask(input logic [N_W-1:0] n);
    logic [CODE_BITS-1:0] mask;
    for (int j = 0; j < CODE_BITS; j++) begin
      mask[j] = (j < int'(n));
    end
    return mask;
  endfunction

  // Bit j set when j + m < n, i.e. the information bits
  function automatic logic [CODE_BITS-1:0] info_mask(input logic [N_W-1:0] n,
                                                     input logic [M_W-1:0] m);
    logic [CODE_BITS-1:0] mask;
    for (int j = 0; j < CODE_BITS; j++) begin
      mask[j] = ((j + int'(m)) < int'(n));
    end
    return mask;
  endfunction

endpackage

FILE: rtl/ldpc_bit_flip_decoder.sv
// Top level of the hard-decision LDPC bit-flipping decoder.
`timescale 1ns / 1ps
`include "ldpc_bit_flip_decoder_assert.svh"
// Usage
//   Command channel: a word is taken at a rising edge with start high and busy low.
//   command_i = load writes row_bits_i into check row row_index_i in that same edge;
//   busy never rises and no result follows, so loads go at one per cycle.
//   command_i = decode latches received_bits_i and raises busy until the result.
//   Result: data_bits_o, iterations_o and converged_o are valid for exactly one cycle
//   while done_o is high; the receiver cannot stall, so the result is simply shown.
//   A decode runs iterations. One whose syndrome fails takes an iteration check,
//   m rows read from the row RAM, a drain state for the registered read, an evaluate
//   state, a 5-step maximum search and a flip. One that converges ends at its
//   evaluate state; the iteration check ends the decode at once when the iteration
//   limit is reached or no checks are in use (m = rows in use).
//   The row RAM read port, one row a cycle, sets the pace.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i; ready only
//   while idle. Index 0 max iterations, 1 code length, 2 check count, others ignored.
//   Reset: registers go to 20, 32, 16; every check row reads as zero until loaded
//   (per-row valid flags, so no clearing pass is needed).
module ldpc_bit_flip_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                command_i,
  input  logic [lbfd_pkg::ROW_IDX_W-1:0]      row_index_i,
  input  logic [lbfd_pkg::WORD_W-1:0]         row_bits_i,
  input  logic [lbfd_pkg::WORD_W-1:0]         received_bits_i,
  // result
  output logic                                done_o,
  output logic [lbfd_pkg::WORD_W-1:0]         data_bits_o,
  output logic [lbfd_pkg::ITER_W-1:0]         iterations_o,
  output logic                                converged_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lbfd_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ITER  = 7'b0000010,
    S_ROWS  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_SRCH  = 7'b0100000,
    S_FLIP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [lbfd_pkg::ITER_W-1:0] max_iter_q;
  logic [lbfd_pkg::CLEN_W-1:0] code_len_q;
  logic [lbfd_pkg::CCNT_W-1:0] chk_cnt_q;

  // decode datapath
  logic [lbfd_pkg::CODE_BITS-1:0]  word_q, word_d;
  logic [lbfd_pkg::ITER_W-1:0]     iter_q, iter_d;
  logic [lbfd_pkg::ROW_AW-1:0]     row_q, row_d;
  logic [lbfd_pkg::CB_W-1:0]       bit_q, bit_d;
  logic                            rd_pend_q, rd_pend_d;
  logic                            rd_vld_q;
  logic                            fail_any_q, fail_any_d;
  logic [lbfd_pkg::CHECK_ROWS-1:0] row_vld_q;

  // result registers
  logic                            done_q, done_d;
  logic [lbfd_pkg::WORD_W-1:0]     data_q, data_d;
  logic [lbfd_pkg::ITER_W-1:0]     iter_out_q, iter_out_d;
  logic                            conv_q, conv_d;

  logic                            accept, load_we, row_ok, last_row;
  logic [lbfd_pkg::N_W-1:0]        n_eff;
  logic [lbfd_pkg::M_W-1:0]        m_eff;
  logic [lbfd_pkg::CODE_BITS-1:0]  nmask, kmask, rd_data, row_eff, cand;
  logic                            par;
  lbfd_pkg::fail_ctl_t             fctl;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  // effective code length and row count, clamped to the built geometry
  assign n_eff = (int'(code_len_q) > lbfd_pkg::CODE_BITS) ?
                 lbfd_pkg::N_W'(lbfd_pkg::CODE_BITS) : lbfd_pkg::N_W'(code_len_q);
  assign m_eff = (int'(chk_cnt_q) > lbfd_pkg::CHECK_ROWS) ?
                 lbfd_pkg::M_W'(lbfd_pkg::CHECK_ROWS) : lbfd_pkg::M_W'(chk_cnt_q);
  assign nmask = lbfd_pkg::low_mask(n_eff);
  assign kmask = lbfd_pkg::info_mask(n_eff, m_eff);

  assign row_ok  = (int'(row_index_i) < lbfd_pkg::CHECK_ROWS);
  assign load_we = accept && (command_i == lbfd_pkg::CMD_LOAD) && row_ok;

  lbfd_ram #(
    .WIDTH (lbfd_pkg::CODE_BITS),
    .DEPTH (lbfd_pkg::CHECK_ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (lbfd_pkg::ROW_AW'(row_index_i)),
    .wdata_i (lbfd_pkg::CODE_BITS'(row_bits_i)),
    .re_i    (state_q == S_ROWS),
    .raddr_i (row_q),
    .rdata_o (rd_data)
  );

  // a row never loaded reads as zero
  assign row_eff  = rd_data & nmask & {lbfd_pkg::CODE_BITS{rd_vld_q}};
  assign par      = ^(row_eff & word_q);
  assign last_row = ((lbfd_pkg::M_W'(row_q) + lbfd_pkg::M_W'(1)) == m_eff);

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    iter_d     = iter_q;
    row_d      = row_q;
    bit_d      = bit_q;
    rd_pend_d  = 1'b0;
    fail_any_d = fail_any_q;
    done_d     = 1'b0;
    data_d     = data_q;
    iter_out_d = iter_out_q;
    conv_d     = conv_q;

    fctl           = '0;
    fctl.bit_sel   = bit_q;
    fctl.init_mask = nmask;

    // parity of the row that arrived this cycle
    if (rd_pend_q) begin
      fctl.accum   = 1'b1;
      fctl.hit_row = par ? row_eff : '0;
      if (par) begin
        fail_any_d = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept && (command_i == lbfd_pkg::CMD_DECODE)) begin
          word_d  = lbfd_pkg::CODE_BITS'(received_bits_i) & nmask;
          iter_d  = '0;
          state_d = S_ITER;
        end
      end
      S_ITER: begin
        if (iter_q == max_iter_q) begin
          // out of iterations
          done_d     = 1'b1;
          data_d     = lbfd_pkg::WORD_W'(word_q & kmask);
          iter_out_d = iter_q;
          conv_d     = 1'b0;
          state_d    = S_IDLE;
        end else if (m_eff == '0) begin
          // no checks in use: converges at once
          done_d     = 1'b1;
          data_d     = lbfd_pkg::WORD_W'(word_q & kmask);
          iter_out_d = iter_q + lbfd_pkg::ITER_W'(1);
          conv_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          iter_d     = iter_q + lbfd_pkg::ITER_W'(1);
          row_d      = '0;
          fail_any_d = 1'b0;
          fctl.clear = 1'b1;
          state_d    = S_ROWS;
        end
      end
      S_ROWS: begin
        rd_pend_d = 1'b1;
        row_d     = row_q + lbfd_pkg::ROW_AW'(1);
        if (last_row) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!fail_any_q) begin
          done_d     = 1'b1;
          data_d     = lbfd_pkg::WORD_W'(word_q & kmask);
          iter_out_d = iter_q;
          conv_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          fctl.srch_init = 1'b1;
          bit_d          = lbfd_pkg::CB_W'(lbfd_pkg::CNT_W - 1);
          state_d        = S_SRCH;
        end
      end
      S_SRCH: begin
        fctl.srch_step = 1'b1;
        if (bit_q == '0) begin
          state_d = S_FLIP;
        end else begin
          bit_d = bit_q - lbfd_pkg::CB_W'(1);
        end
      end
      S_FLIP: begin
        // candidates left are exactly the bits with the top count
        word_d  = word_q ^ cand;
        state_d = S_ITER;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  lbfd_fails u_fails (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fctl),
    .cand_o (cand)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iter_q     <= '0;
      row_q      <= '0;
      bit_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      fail_any_q <= 1'b0;
      row_vld_q  <= '0;
      done_q     <= 1'b0;
      max_iter_q <= lbfd_pkg::MAX_ITER_RST;
      code_len_q <= lbfd_pkg::CODE_LEN_RST;
      chk_cnt_q  <= lbfd_pkg::CHK_CNT_RST;
    end else begin
      state_q    <= state_d;
      iter_q     <= iter_d;
      row_q      <= row_d;
      bit_q      <= bit_d;
      rd_pend_q  <= rd_pend_d;
      rd_vld_q   <= row_vld_q[row_q];
      fail_any_q <= fail_any_d;
      done_q     <= done_d;
      if (load_we) begin
        row_vld_q[lbfd_pkg::ROW_AW'(row_index_i)] <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          lbfd_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[lbfd_pkg::ITER_W-1:0];
          lbfd_pkg::CFG_CODE_LEN: code_len_q <= cfg_data_i[lbfd_pkg::CLEN_W-1:0];
          lbfd_pkg::CFG_CHK_CNT:  chk_cnt_q  <= cfg_data_i[lbfd_pkg::CCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    data_q     <= data_d;
    iter_out_q <= iter_out_d;
    conv_q     <= conv_d;
  end

  assign done_o       = done_q;
  assign data_bits_o  = data_q;
  assign iterations_o = iter_out_q;
  assign converged_o  = conv_q;

  `LBFD_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_q, !done_q, "result strobe longer than one cycle")
  `LBFD_ASSERT_IMP(a_busy_fall, clk_i, rst_ni, $fell(busy), done_q, "decode ended without a result")
  `LBFD_ASSERT_IMP(a_iter_bound, clk_i, rst_ni, done_q, iter_out_q <= max_iter_q, "iteration count above limit")
  `LBFD_ASSERT_IMP(a_conv_iter, clk_i, rst_ni, done_q && conv_q, iter_out_q != '0, "converged with no iteration")

endmodule

FILE: rtl/lbfd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lbfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lbfd_fails.sv
// Per-bit unsatisfied-check counters and the MSB-first maximum search.
`timescale 1ns / 1ps
`include "ldpc_bit_flip_decoder_assert.svh"
module lbfd_fails (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lbfd_pkg::fail_ctl_t               ctl_i,
  output logic [lbfd_pkg::CODE_BITS-1:0]    cand_o
);

  logic [lbfd_pkg::CODE_BITS-1:0][lbfd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [lbfd_pkg::CODE_BITS-1:0] cand_q, cand_d;
  logic [lbfd_pkg::CODE_BITS-1:0] hits;

  always_comb begin
    for (int j = 0; j < lbfd_pkg::CODE_BITS; j++) begin
      hits[j] = cand_q[j] & cnt_q[j][ctl_i.bit_sel];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    cand_d = cand_q;
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.accum) begin
      for (int j = 0; j < lbfd_pkg::CODE_BITS; j++) begin
        cnt_d[j] = cnt_q[j] + lbfd_pkg::CNT_W'(ctl_i.hit_row[j]);
      end
    end
    // keep only the candidates with this count bit set, if any have it
    if (ctl_i.srch_init) begin
      cand_d = ctl_i.init_mask;
    end else if (ctl_i.srch_step && (|hits)) begin
      cand_d = hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cand_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

  `LBFD_ASSERT_NXT(a_clear_zeroes, clk_i, rst_ni, ctl_i.clear, cnt_q == '0, "counters not cleared")
  `LBFD_ASSERT_NXT(a_init_loads, clk_i, rst_ni, ctl_i.srch_init, cand_q == $past(ctl_i.init_mask), "search mask not loaded")
  `LBFD_ASSERT_NXT(a_step_narrows, clk_i, rst_ni, ctl_i.srch_step && !ctl_i.srch_init, (cand_q & ~$past(cand_q)) == '0, "search widened the mask")

endmodule
